// ===== design/repeating_timer_task_list_top_macros.svh =====
`ifndef REPEATING_TIMER_TASK_LIST_TOP_MACROS_SVH
`define REPEATING_TIMER_TASK_LIST_TOP_MACROS_SVH

// Same-cycle check that holds outside reset.
`define RTTL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define RTTL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RTTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rttl_pkg.sv =====
`default_nettype none

package rttl_pkg;

  localparam int TIME_W      = 32;
  localparam int IVAL_W      = 16;
  localparam int RCNT_W      = 17;
  localparam int ID_W        = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    KIND_ADDED  = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [IVAL_W-1:0]        interval;
    logic signed [RCNT_W-1:0] remaining;
    logic [TIME_W-1:0]        next_time;
    logic [ID_W-1:0]          id;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // word accepted this cycle
    logic do_add;
    logic walk;
    logic flush;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_is_add;
    logic empty;
    logic add_done;
    logic step_done;
    logic walk_end;
    logic flush_done;
  } stat_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/rttl_if.sv =====
`default_nettype none

interface rttl_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [31:0]        now;
  logic [15:0]        interval;
  logic signed [16:0] repeat_count;

  modport source (output valid, op, now, interval, repeat_count, input ready);
  modport sink   (input valid, op, now, interval, repeat_count, output ready);
endinterface

interface rttl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] task_id;
  logic        last;

  modport source (output valid, kind, task_id, last, input ready);
  modport sink   (input valid, kind, task_id, last, output ready);
endinterface

`default_nettype wire

// ===== design/rttl_ctrl.sv =====
`default_nettype none

module rttl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rttl_pkg::stat_t stat,
  output rttl_pkg::cmd_t      cmd
);
  import rttl_pkg::*;

  `include "repeating_timer_task_list_top_macros.svh"

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.in_is_add) begin
            state_next = ST_ADD;
          end else if (!stat.empty) begin
            state_next = ST_WALK;
          end
        end
      end
      ST_ADD: begin
        if (stat.add_done) state_next = ST_IDLE;
      end
      ST_WALK: begin
        if (stat.step_done && stat.walk_end) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (stat.flush_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold off the request side while reset is high.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = !rst;
        cmd.start = in_valid && !rst;
      end
      ST_ADD:   cmd.do_add = 1'b1;
      ST_WALK:  cmd.walk   = 1'b1;
      ST_FLUSH: cmd.flush  = 1'b1;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  `RTTL_ASSERT_IMPL(a_walk_nonempty, state == ST_WALK, !stat.empty, "walk over an empty list")

endmodule

`default_nettype wire

// ===== design/rttl_dp.sv =====
`default_nettype none

module rttl_dp #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rttl_pkg::cmd_t      cmd,
  output rttl_pkg::stat_t          stat,
  input  wire logic                in_op,
  input  wire logic [31:0]         in_now,
  input  wire logic [15:0]         in_interval,
  input  wire logic signed [16:0]  in_repeat_count,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_kind,
  output logic [15:0]              out_task_id,
  output logic                     out_last
);
  import rttl_pkg::*;

  `include "repeating_timer_task_list_top_macros.svh"

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  // Captured input word.
  logic                     op_r;
  logic [TIME_W-1:0]        now_r;
  logic [IVAL_W-1:0]        ival_r;
  logic signed [RCNT_W-1:0] rcnt_r;

  entry_t mem [MAX_TASKS];
  entry_t rdata;

  logic [CW-1:0]        count;
  logic [ID_W-1:0]      id_counter;
  logic [IW-1:0]        i;
  logic [CW-1:0]        w;
  logic [RES_CNT_W-1:0] nres;
  logic                 pend_valid;
  logic [ID_W-1:0]      pend_id;

  logic                     out_free;
  logic                     full;
  logic                     fire;
  logic                     report;
  logic                     keep;
  logic                     step_ok;
  logic                     walk_end;
  logic signed [RCNT_W-1:0] rem_new;
  logic [TIME_W-1:0]        next_new;
  logic                     we;
  logic [IW-1:0]            waddr;
  entry_t                   wdata;
  logic                     re;
  logic [IW-1:0]            raddr;
  logic                     add_go;
  logic                     flush_go;

  assign out_free = !out_valid || out_ready;
  assign full     = (count == CW'(MAX_TASKS));

  // Evaluate the entry held in the read register.
  always_comb begin
    fire     = (now_r >= rdata.next_time);
    rem_new  = rdata.remaining;
    next_new = rdata.next_time;
    if (fire) begin
      if (!rdata.remaining[RCNT_W-1] && (rdata.remaining != '0)) begin
        rem_new = rdata.remaining - RCNT_W'(1);
      end
      next_new = sat_add(rdata.next_time, {{(TIME_W-IVAL_W){1'b0}}, rdata.interval});
    end
  end

  assign keep     = (rem_new != '0);
  assign report   = fire && (nres < RES_CNT_W'(MAX_RESULTS));
  // A second report needs the output register to push out the held one.
  assign step_ok  = !(report && pend_valid && !out_free);
  assign walk_end = ((CW'(i) + CW'(1)) == count);
  assign add_go   = cmd.do_add && out_free;
  assign flush_go = cmd.flush && pend_valid && out_free;

  always_comb begin
    we    = 1'b0;
    waddr = w[IW-1:0];
    wdata = '{interval:  rdata.interval,
              remaining: rem_new,
              next_time: next_new,
              id:        rdata.id};
    if (add_go && !full) begin
      we    = 1'b1;
      waddr = count[IW-1:0];
      wdata = '{interval:  ival_r,
                remaining: rcnt_r,
                next_time: sat_add(now_r, {{(TIME_W-IVAL_W){1'b0}}, ival_r}),
                id:        id_counter};
    end else if (cmd.walk && step_ok && keep) begin
      we = 1'b1;
    end
  end

  assign re    = cmd.start || (cmd.walk && step_ok && !walk_end);
  assign raddr = cmd.start ? '0 : IW'(i + 1'b1);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      id_counter <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      i          <= '0;
      w          <= '0;
      nres       <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.start) begin
        i          <= '0;
        w          <= '0;
        nres       <= '0;
        pend_valid <= 1'b0;
      end
      if (add_go) begin
        out_valid <= 1'b1;
        if (!full) begin
          count      <= count + CW'(1);
          id_counter <= id_counter + ID_W'(1);
        end
      end
      if (cmd.walk && step_ok) begin
        if (keep) w <= w + CW'(1);
        if (report) begin
          nres       <= nres + RES_CNT_W'(1);
          pend_valid <= 1'b1;
          if (pend_valid) out_valid <= 1'b1;
        end
        if (walk_end) begin
          count <= keep ? (w + CW'(1)) : w;
        end else begin
          i <= i + IW'(1);
        end
      end
      if (flush_go) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_op;
      now_r  <= in_now;
      ival_r <= in_interval;
      rcnt_r <= in_repeat_count;
    end
    if (add_go) begin
      out_kind    <= full ? KIND_REJECT : KIND_ADDED;
      out_task_id <= full ? '0 : id_counter;
      out_last    <= 1'b1;
    end
    if (cmd.walk && step_ok && report) begin
      pend_id <= rdata.id;
      if (pend_valid) begin
        out_kind    <= KIND_FIRED;
        out_task_id <= pend_id;
        out_last    <= 1'b0;
      end
    end
    if (flush_go) begin
      out_kind    <= KIND_FIRED;
      out_task_id <= pend_id;
      out_last    <= 1'b1;
    end
  end

  always_comb begin
    stat            = '0;
    stat.in_is_add  = !in_op;
    stat.empty      = (count == '0);
    stat.add_done   = out_free && !op_r;
    stat.step_done  = step_ok;
    stat.walk_end   = walk_end;
    stat.flush_done = !pend_valid || out_free;
  end

  `RTTL_ASSERT_ALWAYS(a_count_max, count <= CW'(MAX_TASKS), "entry count above capacity")
  `RTTL_ASSERT_IMPL(a_wr_behind_rd, cmd.walk, w <= CW'(i), "compaction write passed read")
  `RTTL_ASSERT_ALWAYS(a_nres_max, nres <= RES_CNT_W'(MAX_RESULTS), "result count overrun")
  `RTTL_ASSERT_NEXT(a_add_grows, add_go && !full, count == CW'($past(count) + 1'b1), "add lost")

endmodule

`default_nettype wire

// ===== design/repeating_timer_task_list_top.sv =====
// Add: the result word is registered in the add state once the output is free.
// Tick over N stored tasks: walk one task per cycle unless the output stalls;
// the last result word is registered in the flush state that follows the walk.
// A new request word is taken only in idle, once the add or the tick's walk and
// flush are done; an empty-list tick, or one that fires nothing, gives no words.
// Reset (synchronous, rst high) empties the list and zeroes the id counter.
`default_nettype none

module repeating_timer_task_list_top #(
  parameter int MAX_TASKS = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  rttl_req_if.sink  req,
  rttl_rsp_if.source rsp
);
  import rttl_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  // Sequencer: idle, add, walk the list, then flush the held firing.
  rttl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;

  // Task memory, walk pointers and the result register. A firing is held
  // back one step so the final word of a tick can carry last.
  rttl_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (req.op),
    .in_now          (req.now),
    .in_interval     (req.interval),
    .in_repeat_count (req.repeat_count),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_kind        (rsp.kind),
    .out_task_id     (rsp.task_id),
    .out_last        (rsp.last)
  );

endmodule

`default_nettype wire
